/* src/hmv_pkg.sv */
// shared constants and helpers for the half matrix-vector multiplier
package hmv_pkg;

  localparam int LOG_SIZE = 6;
  localparam int VEC_N    = 1 << LOG_SIZE;
  localparam int ROW_W    = 6;

  localparam logic [LOG_SIZE-1:0] IDX_LAST = LOG_SIZE'(VEC_N - 1);

  localparam logic MODE_VECTOR = 1'b0;
  localparam logic MODE_MATRIX = 1'b1;

  // half code: low byte from bits 31..24, high byte from bits 23..16
  function automatic logic [15:0] half_of(input logic [31:0] w);
    half_of = {w[23:16], w[31:24]};
  endfunction

endpackage

/* src/hmv_if.sv */
// valid/ready channel interfaces for input words and row results
interface hmv_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] word;

  modport source (output valid, output mode, output word, input ready);
  modport sink (input valid, input mode, input word, output ready);
endinterface

interface hmv_out_if;
  logic                    valid;
  logic                    ready;
  logic [31:0]             value;
  logic [hmv_pkg::ROW_W-1:0] row;
  logic                    last_row;

  modport source (output valid, output value, output row, output last_row, input ready);
  modport sink (input valid, input value, input row, input last_row, output ready);
endinterface

/* src/hmv_fadd.sv */
// single-precision adder, round to nearest even, normal or zero operands
module hmv_fadd (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] sum_o
);

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    n = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) n = 5'(26 - i);
    end
    lzc27 = n;
  endfunction

  always_comb begin
    logic        swap;
    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  d;
    logic [7:0]  dcap;
    logic [26:0] mb;
    logic [26:0] ms;
    logic [53:0] shw;
    logic [26:0] al;
    logic [27:0] s;
    logic [26:0] nm;
    logic [8:0]  ne;
    logic [4:0]  lz;
    logic        rup;
    logic [24:0] rm;
    logic [8:0]  fe;
    logic [22:0] fr;
    // order operands by magnitude
    swap = b_i[30:0] > a_i[30:0];
    big  = swap ? b_i : a_i;
    sml  = swap ? a_i : b_i;
    mb   = {|big[30:23], big[22:0], 3'b000};
    ms   = {|sml[30:23], sml[22:0], 3'b000};
    // align the smaller one, collapsing lost bits into sticky
    d    = big[30:23] - sml[30:23];
    dcap = (d > 8'd27) ? 8'd27 : d;
    shw  = {ms, 27'd0} >> dcap;
    al   = shw[53:27] | {26'd0, |shw[26:0]};
    // add or subtract magnitudes
    s = (big[31] == sml[31]) ? ({1'b0, mb} + {1'b0, al}) : ({1'b0, mb} - {1'b0, al});
    // normalize
    lz = lzc27(s[26:0]);
    if (s[27]) begin
      nm = s[27:1] | {26'd0, s[0]};
      ne = {1'b0, big[30:23]} + 9'd1;
    end else begin
      nm = s[26:0] << lz;
      ne = {1'b0, big[30:23]} - {4'd0, lz};
    end
    // round to nearest even
    rup = nm[2] & (nm[1] | nm[0] | nm[3]);
    rm  = {1'b0, nm[26:3]} + {24'd0, rup};
    if (rm[24]) begin
      fe = ne + 9'd1;
      fr = rm[23:1];
    end else begin
      fe = ne;
      fr = rm[22:0];
    end
    if (s == 28'd0) sum_o = 32'd0;
    else sum_o = {big[31], fe[7:0], fr};
  end

endmodule

/* src/half_matrix_vector_multiply_top.sv */
// top level: vector store, widening multiplier and row accumulator
// Takes one word per cycle, back to back. Mode 0 words load the vector store
// (64 entries, one synchronous RAM port each way); mode 1 words are matrix
// elements in row-major order. A matrix word passes three stages: RAM read of
// the vector element, exact half-by-half product, then a combinational fp32
// add into the row accumulator. The result word is registered from the adder
// with the row's last product. The pipeline stalls only while a finished row
// meets a result word still waiting at the output; input ready drops for those
// cycles and is low during reset. No clearing pass after reset.
module half_matrix_vector_multiply_top (
  input  logic clk,
  input  logic rst_n,
  hmv_in_if.sink    in_ch,
  hmv_out_if.source out_ch
);

  logic [31:0] mem [hmv_pkg::VEC_N];

  logic [hmv_pkg::LOG_SIZE-1:0] ld_r, col_r, row_r;
  logic [31:0] rd_r, w1_r, prod_r, acc_r, sum;
  logic        s1_valid_r, s1_last_r, s2_valid_r, s2_last_r;
  logic        out_valid_r, out_last_r;
  logic [31:0] out_value_r;
  logic [hmv_pkg::ROW_W-1:0] out_row_r;
  logic        en, in_fire, emit;

  // global advance: hold only when a finished row finds the result slot occupied
  assign en      = !(s2_valid_r && s2_last_r && out_valid_r && !out_ch.ready);
  assign in_ch.ready = en && rst_n;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign emit    = en && s2_valid_r && s2_last_r;

  // vector store write and element read
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.mode == hmv_pkg::MODE_VECTOR) mem[ld_r] <= in_ch.word;
    if (en) begin
      rd_r <= mem[col_r];
      w1_r <= in_ch.word;
    end
  end

  // index counters and stage-one control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_r <= '0;
      col_r <= '0;
      s1_valid_r <= 1'b0;
      s1_last_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_fire && in_ch.mode == hmv_pkg::MODE_MATRIX;
      s1_last_r  <= col_r == hmv_pkg::IDX_LAST;
      if (in_fire && in_ch.mode == hmv_pkg::MODE_VECTOR) ld_r <= ld_r + 1'b1;
      if (in_fire && in_ch.mode == hmv_pkg::MODE_MATRIX) col_r <= col_r + 1'b1;
    end
  end

  // exact product of two widened halves
  logic [15:0] ha, hb;
  logic [21:0] pm;
  logic [7:0]  pe;
  logic [31:0] prod_nxt;
  always_comb begin
    ha = hmv_pkg::half_of(rd_r);
    hb = hmv_pkg::half_of(w1_r);
    pm = {1'b1, ha[9:0]} * {1'b1, hb[9:0]};
    pe = 8'(ha[14:10]) + 8'(hb[14:10]) + 8'd97;
    if (pm[21]) prod_nxt = {ha[15] ^ hb[15], pe + 8'd1, pm[20:0], 2'b00};
    else prod_nxt = {ha[15] ^ hb[15], pe, pm[19:0], 3'b000};
  end

  always_ff @(posedge clk) begin
    if (en) prod_r <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s2_last_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
      s2_last_r  <= s1_last_r;
    end
  end

  // accumulate
  hmv_fadd u_fadd (.a_i(acc_r), .b_i(prod_r), .sum_o(sum));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 32'd0;
      row_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (en && s2_valid_r) acc_r <= s2_last_r ? 32'd0 : sum;
      if (emit) row_r <= row_r + 1'b1;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_value_r <= sum;
      out_row_r   <= hmv_pkg::ROW_W'(row_r);
      out_last_r  <= row_r == hmv_pkg::IDX_LAST;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.value    = out_value_r;
  assign out_ch.row      = out_row_r;
  assign out_ch.last_row = out_last_r;

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r) else $error("row result not presented");
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> acc_r == 32'd0) else $error("accumulator not cleared after row");
  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    emit && row_r == hmv_pkg::IDX_LAST |=> row_r == '0) else $error("row index did not wrap");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(col_r) && $stable(acc_r)) else $error("state moved during stall");

endmodule

/* bench/tb_half_matrix_vector_multiply_top.sv */
// testbench for the half matrix-vector multiplier: streamed words, row results checked
module tb_half_matrix_vector_multiply_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0]               value;
    logic [hmv_pkg::ROW_W-1:0] row;
    logic                      last_row;
  } row_result_t;

  // row dot-product predictor plus queue of pending row sums
  class row_sum_board_t;
    logic [31:0]                  vec_words [hmv_pkg::VEC_N];
    logic [hmv_pkg::LOG_SIZE-1:0] load_idx, col_idx, row_idx;
    logic [31:0]                  acc_bits;
    row_result_t                  pending_rows [$];
    int                           errors, rows_checked;

    function new();
      load_idx = '0; col_idx = '0; row_idx = '0; acc_bits = '0;
      errors = 0; rows_checked = 0;
    endfunction

    // fp32 word as integer units of 2^-50: sig * 2^(exp8 - 100)
    function automatic logic signed [127:0] fp32_units(input logic [31:0] b);
      logic signed [127:0] m;
      int sh;
      if (b[30:0] == '0) return '0;
      m = {104'd0, 1'b1, b[22:0]};
      sh = int'(b[30:23]) - 100;
      if (sh >= 0) m = m <<< sh;
      else m = m >>> (-sh);
      return b[31] ? -m : m;
    endfunction

    // round an exact sum in 2^-50 units to fp32, nearest even
    function automatic logic [31:0] round_units(input logic signed [127:0] v);
      logic [127:0] a, rem, halfw, m;
      int p, sh;
      logic s;
      if (v == 0) return 32'h0;
      s = v < 0;
      a = s ? -v : v;
      p = 127;
      while (!a[p]) p--;
      if (p <= 23) begin
        m = a << (23 - p);
      end else begin
        sh = p - 23;
        m = a >> sh;
        rem = a & ((128'd1 << sh) - 1);
        halfw = 128'd1 << (sh - 1);
        if (rem > halfw || (rem == halfw && m[0])) m = m + 1;
        if (m[24]) begin
          m = m >> 1;
          p++;
        end
      end
      return {s, 8'(p - 50 + 127), m[22:0]};
    endfunction

    function automatic void note_word(input logic mode, input logic [31:0] w);
      logic [15:0] ha, hb;
      logic signed [127:0] prod;
      row_result_t r;
      if (mode == hmv_pkg::MODE_VECTOR) begin
        vec_words[load_idx] = w;
        load_idx++;
        return;
      end
      ha = {vec_words[col_idx][23:16], vec_words[col_idx][31:24]};
      hb = {w[23:16], w[31:24]};
      // product of two 11-bit significands is exact in fp32
      prod = 128'({1'b1, ha[9:0]}) * 128'({1'b1, hb[9:0]});
      prod = prod <<< (int'(ha[14:10]) + int'(hb[14:10]));
      if (ha[15] ^ hb[15]) prod = -prod;
      acc_bits = round_units(fp32_units(acc_bits) + prod);
      if (col_idx != hmv_pkg::IDX_LAST) begin
        col_idx++;
        return;
      end
      r.value = acc_bits;
      r.row = row_idx;
      r.last_row = (row_idx == hmv_pkg::IDX_LAST);
      pending_rows.push_back(r);
      acc_bits = '0;
      col_idx = '0;
      row_idx++;
    endfunction

    task report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    task check_row(input logic [31:0] value, input logic [hmv_pkg::ROW_W-1:0] row,
                   input logic last);
      row_result_t e;
      if (pending_rows.size() == 0) begin
        report("unexpected row word", value, 0);
        return;
      end
      e = pending_rows.pop_front();
      rows_checked++;
      if (value !== e.value) report("value", value, e.value);
      if (row !== e.row) report("row", 32'(row), 32'(e.row));
      if (last !== e.last_row) report("last_row", 32'(last), 32'(e.last_row));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   src_idle = 0, snk_stall = 0;
  int   words_sent = 0;

  hmv_in_if  in_ch ();
  hmv_out_if out_ch ();
  row_sum_board_t board = new();

  half_matrix_vector_multiply_top dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #2 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = hmv_pkg::MODE_VECTOR;
    in_ch.word = '0;
    out_ch.ready = 1'b0;
  end

  // result-side stalls
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_stall);
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result monitor, sampled mid-cycle
  always @(negedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_row(out_ch.value, out_ch.row, out_ch.last_row);
  end

  // send one word, waiting out the handshake
  task automatic send_word(input logic mode, input logic [31:0] w);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.word <= w;
    forever begin
      @(negedge clk);
      if (in_ch.ready) break;
      @(posedge clk);
    end
    board.note_word(mode, w);
    words_sent++;
    @(posedge clk);
  endtask

  // random word, sometimes with an extreme half code
  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(7))
      0: w[31:16] = 16'h0000;
      1: w[31:16] = 16'hFFFF;
      2: w[31:16] = 16'hFF7F;
      3: w[31:16] = 16'h0080;
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    int r, n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: vector of extreme codes, then one row of extremes
    for (int i = 0; i < hmv_pkg::VEC_N; i++)
      send_word(hmv_pkg::MODE_VECTOR, (i % 4 == 0) ? 32'h0000_0000 :
                (i % 4 == 1) ? 32'hFFFF_FFFF :
                (i % 4 == 2) ? 32'hFF7F_0000 : 32'h0080_FFFF);
    for (int j = 0; j < hmv_pkg::VEC_N; j++)
      send_word(hmv_pkg::MODE_MATRIX, (j % 3 == 0) ? 32'hFFFF_0000 :
                (j % 3 == 1) ? 32'h0000_FFFF : 32'h00FC_1234);

    // random: mostly whole rows, with reloads and noise
    while (words_sent < 1900) begin
      case ((words_sent / 500) % 4)
        0: begin src_idle = 0;  snk_stall = 0;  end
        1: begin src_idle = 88; snk_stall = 0;  end
        2: begin src_idle = 0;  snk_stall = 88; end
        default: begin src_idle = 15; snk_stall = 15; end
      endcase
      if ($urandom_range(9) == 0) begin src_idle = 0; snk_stall = 0; end
      r = $urandom_range(99);
      if (r < 70) begin
        for (int j = 0; j < hmv_pkg::VEC_N; j++) begin
          if ($urandom_range(19) == 0) send_word(hmv_pkg::MODE_VECTOR, rand_word());
          send_word(hmv_pkg::MODE_MATRIX, rand_word());
        end
      end else if (r < 85) begin
        for (int i = 0; i < hmv_pkg::VEC_N; i++) send_word(hmv_pkg::MODE_VECTOR, rand_word());
      end else begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) send_word(logic'($urandom_range(1)), rand_word());
      end
    end
    in_ch.valid <= 1'b0;
    src_idle = 0;
    snk_stall = 0;

    // drain, then let the pipeline settle
    while (board.pending_rows.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d words, checked %0d row results across four idle/stall mixes",
             words_sent, board.rows_checked);
    if (board.errors == 0 && board.pending_rows.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
src/hmv_pkg.sv
src/hmv_if.sv
src/hmv_fadd.sv
src/half_matrix_vector_multiply_top.sv
bench/tb_half_matrix_vector_multiply_top.sv
